// ----- sv/ofo_pkg.sv -----
// ----------------------------------------------------------------------------
// ofo_pkg
// Shared types, axis codes and rounding helpers for the frame orthonormalizer.
// ----------------------------------------------------------------------------
package ofo_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;

  localparam logic [1:0] AXIS_I    = 2'd0;
  localparam logic [1:0] AXIS_J    = 2'd1;
  localparam logic [1:0] AXIS_K    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    logic [71:0] m;
    m = v[71] ? 72'(-v) : 72'(v);
    m = (m + 72'h2000_0000) >> 30;
    return v[71] ? -$signed(m) : $signed(m);
  endfunction

  // Position of the highest set bit of a 63-bit magnitude.
  function automatic logic [5:0] msb_pos(input logic [62:0] m);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 63; k++) begin
      if (m[k]) p = 6'(k);
    end
    return p;
  endfunction

endpackage

// ----- sv/ofo_norm.sv -----
// ----------------------------------------------------------------------------
// ofo_norm
// Pipelined 3-vector normalizer: scale to [2^29, 2^30), sum of squares,
// bit-per-stage square root and bit-per-stage division into Q2.30.
// ----------------------------------------------------------------------------
module ofo_norm #(
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  ofo_pkg::s64_t      vec_i [3],
  input  logic [SBW-1:0]     sb_i,
  output logic               v_o,
  output logic               ok_o,
  output ofo_pkg::s32_t      u_o [3],
  output logic [SBW-1:0]     sb_o
);

  localparam int NSQ = 32;
  localparam int NDV = 31;

  // front stages
  logic           a_v_r, b_v_r, c_v_r, d_v_r;
  logic [62:0]    a_mag_r [3];
  logic [62:0]    b_mag_r [3];
  logic [2:0]     a_neg_r, b_neg_r, c_neg_r, d_neg_r;
  logic [SBW-1:0] a_sb_r, b_sb_r, c_sb_r, d_sb_r;
  logic [5:0]     b_pos_r;
  logic           b_zero_r, c_zero_r, d_zero_r;
  logic [29:0]    c_m_r [3];
  logic [29:0]    d_m_r [3];
  logic [59:0]    d_sq_r [3];

  // square root stages
  logic           sq_v_r    [NSQ+1];
  logic [63:0]    sq_n_r    [NSQ+1];
  logic [63:0]    sq_rt_r   [NSQ+1];
  logic [29:0]    sq_m_r    [NSQ+1][3];
  logic [2:0]     sq_neg_r  [NSQ+1];
  logic           sq_zero_r [NSQ+1];
  logic [SBW-1:0] sq_sb_r   [NSQ+1];

  // division stages
  logic           dv_v_r    [NDV+1];
  logic [31:0]    dv_len_r  [NDV+1];
  logic [32:0]    dv_rem_r  [NDV+1][3];
  logic [30:0]    dv_lo_r   [NDV+1][3];
  logic [30:0]    dv_q_r    [NDV+1][3];
  logic [2:0]     dv_neg_r  [NDV+1];
  logic           dv_zero_r [NDV+1];
  logic [SBW-1:0] dv_sb_r   [NDV+1];

  logic           o_v_r, o_ok_r;
  ofo_pkg::s32_t  o_u_r [3];
  logic [SBW-1:0] o_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
      for (int k = 0; k <= NSQ; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= NDV; k++) dv_v_r[k] <= 1'b0;
    end else if (en) begin
      a_v_r <= v_i;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      sq_v_r[0] <= d_v_r;
      for (int k = 0; k < NSQ; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[NSQ];
      for (int k = 0; k < NDV; k++) dv_v_r[k+1] <= dv_v_r[k];
      o_v_r <= dv_v_r[NDV];
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] mg;
    logic [62:0] mx;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [60:0] num;
    logic [32:0] rem2;
    if (en) begin
      // A: magnitudes
      for (int i = 0; i < 3; i++) begin
        mg = vec_i[i][63] ? 64'(-vec_i[i]) : 64'(vec_i[i]);
        a_mag_r[i] <= mg[62:0];
        a_neg_r[i] <= vec_i[i][63];
      end
      a_sb_r <= sb_i;
      // B: largest magnitude and its leading one
      mx = a_mag_r[0];
      if (a_mag_r[1] > mx) mx = a_mag_r[1];
      if (a_mag_r[2] > mx) mx = a_mag_r[2];
      b_pos_r  <= ofo_pkg::msb_pos(mx);
      b_zero_r <= (mx == '0);
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_sb_r   <= a_sb_r;
      // C: common power-of-two scaling
      for (int i = 0; i < 3; i++) begin
        if (b_pos_r >= 6'd29) c_m_r[i] <= 30'(b_mag_r[i] >> (b_pos_r - 6'd29));
        else                  c_m_r[i] <= 30'(b_mag_r[i] << (6'd29 - b_pos_r));
      end
      c_zero_r <= b_zero_r;
      c_neg_r  <= b_neg_r;
      c_sb_r   <= b_sb_r;
      // D: squares
      for (int i = 0; i < 3; i++) d_sq_r[i] <= 60'(c_m_r[i]) * 60'(c_m_r[i]);
      d_m_r    <= c_m_r;
      d_zero_r <= c_zero_r;
      d_neg_r  <= c_neg_r;
      d_sb_r   <= c_sb_r;
      // square root load
      sq_n_r[0]    <= 64'(d_sq_r[0]) + 64'(d_sq_r[1]) + 64'(d_sq_r[2]);
      sq_rt_r[0]   <= '0;
      sq_m_r[0]    <= d_m_r;
      sq_neg_r[0]  <= d_neg_r;
      sq_zero_r[0] <= d_zero_r;
      sq_sb_r[0]   <= d_sb_r;
      // one result bit per stage
      for (int k = 0; k < NSQ; k++) begin
        bitv  = 64'd1 << (62 - 2 * k);
        trial = sq_rt_r[k] + bitv;
        if (sq_n_r[k] >= trial) begin
          sq_n_r[k+1]  <= sq_n_r[k] - trial;
          sq_rt_r[k+1] <= (sq_rt_r[k] >> 1) + bitv;
        end else begin
          sq_n_r[k+1]  <= sq_n_r[k];
          sq_rt_r[k+1] <= sq_rt_r[k] >> 1;
        end
        sq_m_r[k+1]    <= sq_m_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_zero_r[k+1] <= sq_zero_r[k];
        sq_sb_r[k+1]   <= sq_sb_r[k];
      end
      // division load: numerator is m * 2^30 plus half the length
      dv_len_r[0] <= sq_rt_r[NSQ][31:0];
      for (int i = 0; i < 3; i++) begin
        num = {1'b0, sq_m_r[NSQ][i], 30'd0} + 61'(sq_rt_r[NSQ][31:1]);
        dv_rem_r[0][i] <= 33'(num[60:31]);
        dv_lo_r[0][i]  <= num[30:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_neg_r[0]  <= sq_neg_r[NSQ];
      dv_zero_r[0] <= sq_zero_r[NSQ];
      dv_sb_r[0]   <= sq_sb_r[NSQ];
      // one quotient bit per stage
      for (int k = 0; k < NDV; k++) begin
        for (int i = 0; i < 3; i++) begin
          rem2 = {dv_rem_r[k][i][31:0], dv_lo_r[k][i][5'(NDV - 1 - k)]};
          if (rem2 >= 33'(dv_len_r[k])) begin
            dv_rem_r[k+1][i] <= rem2 - 33'(dv_len_r[k]);
            dv_q_r[k+1][i]   <= {dv_q_r[k][i][29:0], 1'b1};
          end else begin
            dv_rem_r[k+1][i] <= rem2;
            dv_q_r[k+1][i]   <= {dv_q_r[k][i][29:0], 1'b0};
          end
          dv_lo_r[k+1][i] <= dv_lo_r[k][i];
        end
        dv_len_r[k+1]  <= dv_len_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_sb_r[k+1]   <= dv_sb_r[k];
      end
      // output: restore signs, a zero vector stays zero
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[NDV])         o_u_r[i] <= '0;
        else if (dv_neg_r[NDV][i])  o_u_r[i] <= -$signed(32'(dv_q_r[NDV][i]));
        else                        o_u_r[i] <= $signed(32'(dv_q_r[NDV][i]));
      end
      o_ok_r <= !dv_zero_r[NDV];
      o_sb_r <= dv_sb_r[NDV];
    end
  end

  assign v_o  = o_v_r;
  assign ok_o = o_ok_r;
  assign u_o  = o_u_r;
  assign sb_o = o_sb_r;

endmodule

// ----- sv/ofo_proj.sv -----
// ----------------------------------------------------------------------------
// ofo_proj
// Projects a Q16.16 candidate off a Q2.30 unit axis and picks either the
// projection or the reduced basis-axis fallback, in seven stages.
// ----------------------------------------------------------------------------
module ofo_proj #(
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  ofo_pkg::s32_t  c_i [3],
  input  ofo_pkg::s32_t  n_i [3],
  input  logic [15:0]    min_len_i,
  input  logic [SBW-1:0] sb_i,
  output logic           v_o,
  output ofo_pkg::s64_t  p_o [3],
  output logic [SBW-1:0] sb_o
);

  logic [6:0]            v_r;
  logic [SBW-1:0]        sb_r [7];
  ofo_pkg::s32_t         c_r  [4][3];
  ofo_pkg::s32_t         n_r  [4][3];
  logic [1:0]            s1_r, s2_r;
  logic signed [63:0]    prod1_r [3];
  logic signed [65:0]    dot2_r;
  logic signed [63:0]    nn2_r [3];
  logic signed [35:0]    dotr3_r;
  logic signed [33:0]    q_r [4][3];
  logic signed [67:0]    m4_r [3];
  logic signed [43:0]    p_r [2][3];
  logic                  long6_r;
  logic [31:0]           sq6_r [3];
  logic [31:0]           tt6_r;
  ofo_pkg::s64_t         p7_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[5:0], v_i};
  end

  always_ff @(posedge clk) begin
    logic [31:0]        a0, a1, a2;
    logic signed [71:0] t72;
    logic signed [33:0] base;
    logic [43:0]        pm;
    logic               lng;
    logic [33:0]        ssq;
    if (en) begin
      sb_r[0] <= sb_i;
      for (int k = 0; k < 6; k++) sb_r[k+1] <= sb_r[k];
      c_r[0] <= c_i;
      for (int k = 0; k < 3; k++) c_r[k+1] <= c_r[k];
      n_r[0] <= n_i;
      for (int k = 0; k < 3; k++) n_r[k+1] <= n_r[k];
      // P1: dot partial products and fallback seed axis
      for (int i = 0; i < 3; i++) prod1_r[i] <= c_i[i] * n_i[i];
      a0 = n_i[0][31] ? 32'(-n_i[0]) : 32'(n_i[0]);
      a1 = n_i[1][31] ? 32'(-n_i[1]) : 32'(n_i[1]);
      a2 = n_i[2][31] ? 32'(-n_i[2]) : 32'(n_i[2]);
      priority if (a0 <= a1 && a0 <= a2) s1_r <= 2'd0;
      else if (a1 <= a2)                 s1_r <= 2'd1;
      else                               s1_r <= 2'd2;
      // P2
      dot2_r <= 66'(prod1_r[0]) + 66'(prod1_r[1]) + 66'(prod1_r[2]);
      for (int i = 0; i < 3; i++) nn2_r[i] <= n_r[0][i] * n_r[0][s1_r];
      s2_r <= s1_r;
      // P3: round the dot product, build the fallback vector
      t72     = ofo_pkg::rnd30(72'(dot2_r));
      dotr3_r <= t72[35:0];
      for (int i = 0; i < 3; i++) begin
        base = (2'(i) == s2_r) ? ofo_pkg::ONE_Q30 : 34'sd0;
        t72  = ofo_pkg::rnd30(72'(nn2_r[i]));
        q_r[0][i] <= base - t72[33:0];
      end
      // P4
      for (int i = 0; i < 3; i++) m4_r[i] <= n_r[2][i] * dotr3_r;
      q_r[1] <= q_r[0];
      // P5: projected component
      for (int i = 0; i < 3; i++) begin
        t72 = ofo_pkg::rnd30(72'(m4_r[i]));
        p_r[0][i] <= 44'(c_r[3][i]) - t72[43:0];
      end
      q_r[2] <= q_r[1];
      // P6: length test parts
      lng = 1'b0;
      for (int i = 0; i < 3; i++) begin
        pm = p_r[0][i][43] ? 44'(-p_r[0][i]) : 44'(p_r[0][i]);
        if (pm >= 44'd65536) lng = 1'b1;
        sq6_r[i] <= 32'(pm[15:0]) * 32'(pm[15:0]);
      end
      long6_r <= lng;
      tt6_r   <= 32'(min_len_i) * 32'(min_len_i);
      p_r[1]  <= p_r[0];
      q_r[3]  <= q_r[2];
      // P7: choose projection or fallback
      ssq = 34'(sq6_r[0]) + 34'(sq6_r[1]) + 34'(sq6_r[2]);
      for (int i = 0; i < 3; i++) begin
        if (long6_r || ssq > 34'(tt6_r)) p7_r[i] <= 64'(p_r[1][i]);
        else                             p7_r[i] <= 64'(q_r[3][i]);
      end
    end
  end

  assign v_o  = v_r[6];
  assign p_o  = p7_r;
  assign sb_o = sb_r[6];

endmodule

// ----- sv/ofo_cross.sv -----
// ----------------------------------------------------------------------------
// ofo_cross
// Exact cross product of two Q2.30 vectors in two stages.
// ----------------------------------------------------------------------------
module ofo_cross #(
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  ofo_pkg::s32_t  a_i [3],
  input  ofo_pkg::s32_t  b_i [3],
  input  logic [SBW-1:0] sb_i,
  output logic           v_o,
  output ofo_pkg::s64_t  c_o [3],
  output logic [SBW-1:0] sb_o
);

  logic [1:0]         v_r;
  logic signed [63:0] p_r [6];
  ofo_pkg::s64_t      c_r [3];
  logic [SBW-1:0]     sb1_r, sb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[0], v_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= a_i[1] * b_i[2];
      p_r[1] <= a_i[2] * b_i[1];
      p_r[2] <= a_i[2] * b_i[0];
      p_r[3] <= a_i[0] * b_i[2];
      p_r[4] <= a_i[0] * b_i[1];
      p_r[5] <= a_i[1] * b_i[0];
      sb1_r  <= sb_i;
      c_r[0] <= p_r[0] - p_r[1];
      c_r[1] <= p_r[2] - p_r[3];
      c_r[2] <= p_r[4] - p_r[5];
      sb2_r  <= sb1_r;
    end
  end

  assign v_o  = v_r[1];
  assign c_o  = c_r;
  assign sb_o = sb2_r;

endmodule

// ----- sv/edited_axis_frame_orthonormalize_top.sv -----
// ----------------------------------------------------------------------------
// edited_axis_frame_orthonormalize_top
// Builds a right-handed orthonormal Q2.22 frame around an edited axis.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output side keeps taking
// words, and returns one result word per input word, in order. The pipeline
// is made of four chained normalizers of 70 stages each (with a stage for
// each square-root bit and each quotient bit), the seven-stage projection,
// two two-stage cross products and the output register. When out_tready is
// low with a word waiting, the whole pipeline holds.
module edited_axis_frame_orthonormalize_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // i_cand_x, i_cand_y, i_cand_z, j_cand_x, j_cand_y, j_cand_z,
  // k_cand_x, k_cand_y, k_cand_z (32 bits each)
  input  logic [287:0] in_tdata,
  // edited_axis
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // i_out_x, i_out_y, i_out_z, j_out_x, j_out_y, j_out_z,
  // k_out_x, k_out_y, k_out_z (24 bits each)
  output logic [215:0] out_tdata,
  // status
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int SB1 = 98;
  localparam int SB2 = 99;
  localparam int SB3 = 195;

  logic          en;
  logic [15:0]   min_len_r;
  ofo_pkg::s32_t ci [3], cj [3], ck [3], cs [3];
  ofo_pkg::s64_t e64 [3];

  logic          v1, ok1;
  ofo_pkg::s32_t n1 [3];
  logic [SB1-1:0] sb1, sb1_in;

  logic          vp;
  ofo_pkg::s64_t pv [3];
  logic [SB2-1:0] sbp, sbp_in;

  logic          v2;
  ofo_pkg::s32_t s2 [3];
  logic [SB2-1:0] sb2;

  logic          vx1, v3;
  ofo_pkg::s32_t n2 [3], xa [3], xb [3];
  ofo_pkg::s64_t x1 [3];
  logic [SB3-1:0] sbx1_in, sbx1, sb3;
  ofo_pkg::s32_t t3 [3];

  logic          vx2, v4;
  ofo_pkg::s32_t n3 [3], ya [3], yb [3];
  ofo_pkg::s64_t x2 [3];
  logic [SB3-1:0] sbx2_in, sbx2, sb4;
  ofo_pkg::s32_t w4 [3], n4 [3], t4 [3];
  logic [1:0]    ax4;
  logic          ok4;

  ofo_pkg::s32_t fi [3], fj [3], fk [3];
  logic          st;
  logic          out_v_r;
  logic [215:0]  out_d_r;
  logic          out_s_r;

  function automatic logic [23:0] rnd8(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? 33'(-33'(v)) : 33'(v);
    m = (m + 33'd128) >> 8;
    return v[31] ? 24'(-m) : 24'(m);
  endfunction

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) min_len_r <= '0;
    else if (cfg_valid) min_len_r <= cfg_data;
  end

  // Edited candidate goes to the first normalizer, the second one rides along.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ci[a] = in_tdata[32*a +: 32];
      cj[a] = in_tdata[96 + 32*a +: 32];
      ck[a] = in_tdata[192 + 32*a +: 32];
    end
    unique case (in_tuser)
      ofo_pkg::AXIS_J: begin
        for (int a = 0; a < 3; a++) e64[a] = 64'(cj[a]);
        cs = ci;
      end
      ofo_pkg::AXIS_K: begin
        for (int a = 0; a < 3; a++) e64[a] = 64'(ck[a]);
        cs = ci;
      end
      ofo_pkg::AXIS_I: begin
        for (int a = 0; a < 3; a++) e64[a] = 64'(ci[a]);
        cs = cj;
      end
      default: begin
        for (int a = 0; a < 3; a++) e64[a] = 64'(ci[a]);
        cs = ci;
      end
    endcase
  end

  assign sb1_in = {cs[2], cs[1], cs[0], in_tuser};

  ofo_norm #(.SBW(SB1)) u_norm_edit (
    .clk, .rst_n, .en, .v_i(in_tvalid && en), .vec_i(e64), .sb_i(sb1_in),
    .v_o(v1), .ok_o(ok1), .u_o(n1), .sb_o(sb1)
  );

  ofo_pkg::s32_t c1 [3];
  always_comb begin
    for (int a = 0; a < 3; a++) c1[a] = sb1[2 + 32*a +: 32];
  end
  assign sbp_in = {n1[2], n1[1], n1[0], ok1, sb1[1:0]};

  ofo_proj #(.SBW(SB2)) u_proj (
    .clk, .rst_n, .en, .v_i(v1), .c_i(c1), .n_i(n1), .min_len_i(min_len_r),
    .sb_i(sbp_in), .v_o(vp), .p_o(pv), .sb_o(sbp)
  );

  ofo_norm #(.SBW(SB2)) u_norm_second (
    .clk, .rst_n, .en, .v_i(vp), .vec_i(pv), .sb_i(sbp),
    .v_o(v2), .ok_o(), .u_o(s2), .sb_o(sb2)
  );

  // First cross: (n, s) for axes i and k, (s, n) for axis j.
  always_comb begin
    for (int a = 0; a < 3; a++) n2[a] = sb2[3 + 32*a +: 32];
    if (sb2[1:0] == ofo_pkg::AXIS_J) begin
      xa = s2;
      xb = n2;
    end else begin
      xa = n2;
      xb = s2;
    end
  end
  assign sbx1_in = {s2[2], s2[1], s2[0], sb2};

  ofo_cross #(.SBW(SB3)) u_cross_third (
    .clk, .rst_n, .en, .v_i(v2), .a_i(xa), .b_i(xb), .sb_i(sbx1_in),
    .v_o(vx1), .c_o(x1), .sb_o(sbx1)
  );

  ofo_norm #(.SBW(SB3)) u_norm_third (
    .clk, .rst_n, .en, .v_i(vx1), .vec_i(x1), .sb_i(sbx1),
    .v_o(v3), .ok_o(), .u_o(t3), .sb_o(sb3)
  );

  // Second cross rebuilds the projected axis: (n, t) for axis j, else (t, n).
  always_comb begin
    for (int a = 0; a < 3; a++) n3[a] = sb3[3 + 32*a +: 32];
    if (sb3[1:0] == ofo_pkg::AXIS_J) begin
      ya = n3;
      yb = t3;
    end else begin
      ya = t3;
      yb = n3;
    end
  end
  assign sbx2_in = {t3[2], t3[1], t3[0], sb3[SB2-1:0]};

  ofo_cross #(.SBW(SB3)) u_cross_rebuild (
    .clk, .rst_n, .en, .v_i(v3), .a_i(ya), .b_i(yb), .sb_i(sbx2_in),
    .v_o(vx2), .c_o(x2), .sb_o(sbx2)
  );

  ofo_norm #(.SBW(SB3)) u_norm_rebuild (
    .clk, .rst_n, .en, .v_i(vx2), .vec_i(x2), .sb_i(sbx2),
    .v_o(v4), .ok_o(), .u_o(w4), .sb_o(sb4)
  );

  always_comb begin
    ax4 = sb4[1:0];
    ok4 = sb4[2];
    for (int a = 0; a < 3; a++) begin
      n4[a] = sb4[3 + 32*a +: 32];
      t4[a] = sb4[SB2 + 32*a +: 32];
    end
    st = 1'b0;
    unique case (ax4)
      ofo_pkg::AXIS_I: begin
        fi = n4; fj = w4; fk = t4;
      end
      ofo_pkg::AXIS_J: begin
        fi = w4; fj = n4; fk = t4;
      end
      ofo_pkg::AXIS_K: begin
        fi = w4; fj = t4; fk = n4;
      end
      default: begin
        fi = '{32'sh4000_0000, 32'sd0, 32'sd0};
        fj = '{32'sd0, 32'sh4000_0000, 32'sd0};
        fk = '{32'sd0, 32'sd0, 32'sh4000_0000};
      end
    endcase
    // A zero edited vector reports status and clears the frame.
    if (ax4 != ofo_pkg::AXIS_NONE && !ok4) begin
      st = 1'b1;
      fi = '{32'sd0, 32'sd0, 32'sd0};
      fj = '{32'sd0, 32'sd0, 32'sd0};
      fk = '{32'sd0, 32'sd0, 32'sd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        out_d_r[24*a +: 24]       <= rnd8(fi[a]);
        out_d_r[72 + 24*a +: 24]  <= rnd8(fj[a]);
        out_d_r[144 + 24*a +: 24] <= rnd8(fk[a]);
      end
      out_s_r <= st;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_s_r;

`ifndef SYNTH
  a_status_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("status set with a nonzero frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while the pipeline was held");

  a_cfg_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(min_len_r))
    else $error("threshold changed without a configuration write");
`endif

endmodule

// ----- sim/edited_axis_frame_orthonormalize_top_tb.sv -----
// ----------------------------------------------------------------------------
// edited_axis_frame_orthonormalize_top_tb
// Self-checking bench for the edited-axis frame orthonormalizer. Directed
// frames go in first, then random frames under several idle and stall
// patterns. Results are compared field by field with predicted or set frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module edited_axis_frame_orthonormalize_top_tb;

  localparam int LATENCY     = 292;
  localparam int WATCH_LIMIT = 20000;
  localparam int N_RANDOM    = 750;

  typedef struct {
    logic               status;
    logic signed [23:0] f [9];
  } frame_t;

  typedef struct {
    logic [1:0]         axis;
    logic signed [31:0] c [9];
  } frame_in_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [215:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  edited_axis_frame_orthonormalize_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [15:0] min_proj_len;
  frame_t      frames_pending [$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // ---------------- predictor ----------------
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic [63:0] m;
    m = (mag(v) + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to unit length in Q2.30; a zero vector stays zero.
  function automatic logic unit_vec(input logic signed [63:0] v [3],
                                    output logic signed [63:0] u [3]);
    logic [63:0] m [3];
    logic [63:0] mx, sum, len, q;
    int rs, ls;
    mx = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin mx = mx >> 1; rs++; end
    while (mx < (64'd1 << 29)) begin mx = mx << 1; ls++; end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sum += m[i] * m[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
    return 1'b1;
  endfunction

  function automatic void unit_cross(input logic signed [63:0] a [3],
                                     input logic signed [63:0] b [3],
                                     output logic signed [63:0] o [3]);
    logic signed [63:0] c [3];
    logic ok;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    ok = unit_vec(c, o);
  endfunction

  // Removes the edited-axis part of c; a too short remainder is replaced by
  // the reduced basis axis at the edited axis' smallest component.
  function automatic void perpendicular(input logic signed [63:0] c [3],
                                        input logic signed [63:0] n [3],
                                        output logic signed [63:0] o [3]);
    logic signed [63:0] p [3], q [3];
    logic signed [63:0] dot;
    logic [63:0] ssq, pm, a0, a1, a2, thr;
    logic longer, ok;
    int s;
    ssq = 0; longer = 1'b0;
    dot = round_shift(c[0] * n[0] + c[1] * n[1] + c[2] * n[2], 30);
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i] - round_shift(n[i] * dot, 30);
      pm = mag(p[i]);
      if (pm >= 65536) longer = 1'b1;
      else ssq += pm * pm;
    end
    thr = 64'(min_proj_len);
    if (longer || ssq > thr * thr) begin
      ok = unit_vec(p, o);
      return;
    end
    a0 = mag(n[0]); a1 = mag(n[1]); a2 = mag(n[2]);
    if (a0 <= a1 && a0 <= a2) s = 0;
    else if (a1 <= a2) s = 1;
    else s = 2;
    for (int i = 0; i < 3; i++)
      q[i] = (i == s ? 64'sd1 << 30 : 64'sd0) - round_shift(n[i] * n[s], 30);
    ok = unit_vec(q, o);
  endfunction

  function automatic frame_t predict_frame(input frame_in_t x);
    logic signed [63:0] ci [3], cj [3], ck [3];
    logic signed [63:0] fi [3], fj [3], fk [3], t [3];
    logic ok;
    frame_t r;
    for (int a = 0; a < 3; a++) begin
      ci[a] = x.c[a]; cj[a] = x.c[3 + a]; ck[a] = x.c[6 + a];
      fi[a] = 0; fj[a] = 0; fk[a] = 0;
    end
    fi[0] = 64'sd1 << 30; fj[1] = 64'sd1 << 30; fk[2] = 64'sd1 << 30;
    ok = 1'b1;
    case (x.axis)
      ofo_pkg::AXIS_I: begin
        ok = unit_vec(ci, fi);
        if (ok) begin
          perpendicular(cj, fi, fj);
          unit_cross(fi, fj, fk);
          unit_cross(fk, fi, t);
          fj = t;
        end
      end
      ofo_pkg::AXIS_J: begin
        ok = unit_vec(cj, fj);
        if (ok) begin
          perpendicular(ci, fj, fi);
          unit_cross(fi, fj, fk);
          unit_cross(fj, fk, t);
          fi = t;
        end
      end
      ofo_pkg::AXIS_K: begin
        ok = unit_vec(ck, fk);
        if (ok) begin
          perpendicular(ci, fk, fi);
          unit_cross(fk, fi, fj);
          unit_cross(fj, fk, t);
          fi = t;
        end
      end
      default: ;
    endcase
    r.status = !ok;
    for (int a = 0; a < 3; a++) begin
      r.f[a]     = ok ? 24'(round_shift(fi[a], 8)) : '0;
      r.f[3 + a] = ok ? 24'(round_shift(fj[a], 8)) : '0;
      r.f[6 + a] = ok ? 24'(round_shift(fk[a], 8)) : '0;
    end
    return r;
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    frame_t exp_f;
    if (rst_n && out_tvalid && out_tready) begin
      idle_cycles <= 0;
      if (frames_pending.size() == 0) begin
        $display("%0t: unexpected result word tdata=%h tuser=%b",
                 $time, out_tdata, out_tuser);
        n_errors++;
      end else begin
        exp_f = frames_pending.pop_front();
        if (out_tuser !== exp_f.status) begin
          $display("%0t: status expected %b actual %b", $time, exp_f.status, out_tuser);
          n_errors++;
        end
        for (int k = 0; k < 9; k++) begin
          if (out_tdata[24*k +: 24] !== exp_f.f[k]) begin
            $display("%0t: field %0d expected %h actual %h",
                     $time, k, exp_f.f[k], out_tdata[24*k +: 24]);
            n_errors++;
          end
        end
      end
    end else if (rst_n && in_tvalid && in_tready) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------- stimulus ----------------
  task automatic send_frame(input frame_in_t x);
    logic [287:0] d;
    for (int k = 0; k < 9; k++) d[32*k +: 32] = x.c[k];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= x.axis;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames_pending.push_back(predict_frame(x));
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (frames_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_proj_len = v;
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(131072)) - 32'sd65536);
      2: return 32'sd0;
      3: return $signed($urandom()) >>> $urandom_range(31);
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed(32'($urandom_range(16)) - 32'sd8);
    endcase
  endfunction

  function automatic frame_in_t rand_frame();
    frame_in_t x;
    logic signed [31:0] sc;
    x.axis = ($urandom_range(19) == 0) ? ofo_pkg::AXIS_NONE : 2'($urandom_range(2));
    for (int k = 0; k < 9; k++) x.c[k] = rand_comp();
    // Often make the second candidate nearly parallel to the edited one,
    // so that the short-projection fallback is exercised.
    if ($urandom_range(3) == 0) begin
      sc = $urandom_range(3) - 1;
      for (int a = 0; a < 3; a++) begin
        logic signed [31:0] e;
        e = x.c[(x.axis == ofo_pkg::AXIS_K ? 6 : x.axis == ofo_pkg::AXIS_J ? 3 : 0) + a];
        if (x.axis == ofo_pkg::AXIS_I)
          x.c[3 + a] = e * sc + $signed(32'($urandom_range(4)) - 2);
        else x.c[a] = e * sc + $signed(32'($urandom_range(4)) - 2);
      end
    end
    return x;
  endfunction

  typedef struct {
    logic [1:0]         axis;
    logic signed [31:0] c [9];
    logic               known;
    frame_t             res;
  } directed_row_t;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [23:0] U    = 24'sh40_0000;

  directed_row_t dir_rows [$];

  function automatic frame_t ident();
    frame_t r;
    r.status = 1'b0;
    for (int k = 0; k < 9; k++) r.f[k] = '0;
    r.f[0] = U; r.f[4] = U; r.f[8] = U;
    return r;
  endfunction

  function automatic frame_t zero_status();
    frame_t r;
    r.status = 1'b1;
    for (int k = 0; k < 9; k++) r.f[k] = '0;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] ax, input logic signed [31:0] c [9],
                         input logic known, input frame_t res);
    directed_row_t d;
    d.axis = ax; d.c = c; d.known = known; d.res = res;
    dir_rows.push_back(d);
  endtask

  task automatic build_directed();
    logic signed [31:0] c [9];
    for (int k = 0; k < 9; k++) c[k] = 0;
    // All zero edited vectors, and the unused axis code.
    add_row(ofo_pkg::AXIS_I, c, 1'b1, zero_status());
    add_row(ofo_pkg::AXIS_J, c, 1'b1, zero_status());
    add_row(ofo_pkg::AXIS_K, c, 1'b1, zero_status());
    add_row(ofo_pkg::AXIS_NONE, c, 1'b1, ident());
    // Basis frame given exactly.
    c[0] = ONE; c[4] = ONE; c[8] = ONE;
    add_row(ofo_pkg::AXIS_I, c, 1'b1, ident());
    add_row(ofo_pkg::AXIS_J, c, 1'b1, ident());
    add_row(ofo_pkg::AXIS_K, c, 1'b1, ident());
    // Parallel second candidate: fallback, ties in the smallest component.
    for (int k = 0; k < 9; k++) c[k] = 0;
    c[0] = ONE; c[3] = ONE; c[6] = ONE;
    add_row(ofo_pkg::AXIS_I, c, 1'b0, ident());
    c[0] = ONE; c[1] = ONE; c[2] = ONE; c[3] = ONE; c[4] = ONE; c[5] = ONE;
    add_row(ofo_pkg::AXIS_I, c, 1'b0, ident());
    add_row(ofo_pkg::AXIS_J, c, 1'b0, ident());
    c[6] = ONE; c[7] = ONE; c[8] = ONE;
    add_row(ofo_pkg::AXIS_K, c, 1'b0, ident());
    // Extremes of the fields.
    for (int k = 0; k < 9; k++) c[k] = SMAX;
    add_row(ofo_pkg::AXIS_I, c, 1'b0, ident());
    for (int k = 0; k < 9; k++) c[k] = SMIN;
    add_row(ofo_pkg::AXIS_J, c, 1'b0, ident());
    add_row(ofo_pkg::AXIS_NONE, c, 1'b1, ident());
    for (int k = 0; k < 9; k++) c[k] = (k % 2) ? SMIN : SMAX;
    add_row(ofo_pkg::AXIS_K, c, 1'b0, ident());
    for (int k = 0; k < 9; k++) c[k] = (k % 3 == 0) ? 32'sd1 : -32'sd1;
    add_row(ofo_pkg::AXIS_I, c, 1'b0, ident());
    // Zero second candidate.
    for (int k = 0; k < 9; k++) c[k] = 0;
    c[1] = -ONE;
    add_row(ofo_pkg::AXIS_I, c, 1'b0, ident());
    c[1] = 0; c[5] = 32'sd3;
    add_row(ofo_pkg::AXIS_J, c, 1'b0, ident());
  endtask

  initial begin
    frame_in_t x;
    min_proj_len = '0;
    build_directed();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      x.axis = dir_rows[r].axis;
      x.c    = dir_rows[r].c;
      send_frame(x);
      if (dir_rows[r].known) begin
        void'(frames_pending.pop_back());
        frames_pending.push_back(dir_rows[r].res);
      end
    end
    drain_and_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(16'hFFFF);
        1: write_threshold(16'd0);
        2: write_threshold(16'($urandom_range(65535)));
        3: write_threshold(16'($urandom_range(255)));
        default: write_threshold(16'h8000);
      endcase
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) send_frame(rand_frame());
      drain_and_idle();
    end

    if (n_errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- edited_axis_frame_orthonormalize_top.f -----
sv/ofo_pkg.sv
sv/ofo_norm.sv
sv/ofo_proj.sv
sv/ofo_cross.sv
sv/edited_axis_frame_orthonormalize_top.sv
sim/edited_axis_frame_orthonormalize_top_tb.sv
